// ===== sv/rltb_pkg.sv =====
// shared constants, types and codes of the radial lamp tint blend
// no dependencies; compiled first
package rltb_pkg;

  // field widths
  localparam int PIX_XY_W   = 8;
  localparam int COLOR_W    = 16;
  localparam int CH_W       = 5;
  localparam int TINT_W     = 15;
  localparam int CENTER_W   = 10;
  localparam int RADIUS_W   = 6;
  localparam int ALPHA_W    = 3;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X = 2'd0,
    CFG_CENTER_Y = 2'd1,
    CFG_RADIUS   = 2'd2,
    CFG_TINT     = 2'd3
  } cfg_idx_e;

  // screen size defaults
  localparam int SCREEN_WIDTH_DEF  = 256;
  localparam int SCREEN_HEIGHT_DEF = 192;

  // blend weight and lamp geometry
  localparam int MAX_ALPHA    = 7;
  localparam int R2_W         = 2 * RADIUS_W;
  localparam int VMIN_W       = 10;
  localparam int INV_W        = 19;
  localparam int INV_NUM      = MAX_ALPHA << 16;
  localparam int SEVEN_RECIP  = 9363;       // ceil(2^16 / 7), exact for r2 below 13107
  localparam int SEVEN_RCP_W  = 14;
  localparam int SEVEN_RCP_SH = 16;

  localparam int RADIUS_RESET = 16;
  localparam int R2_RESET     = RADIUS_RESET * RADIUS_RESET;
  localparam int VMIN_RESET   = R2_RESET / MAX_ALPHA;
  localparam int INV_RESET    = (INV_NUM + R2_RESET - 1) / R2_RESET;

  localparam logic [COLOR_W-1:0] BLEND_MARK = 16'h8000;

  typedef struct packed {
    logic [R2_W-1:0]   r2;
    logic [VMIN_W-1:0] vmin;
    logic [INV_W-1:0]  inv;
  } geom_t;

  typedef struct packed {
    logic [COLOR_W-1:0] out_color;
    logic               tinted;
    logic [ALPHA_W-1:0] strength;
  } result_t;

  typedef enum logic [1:0] {
    RC_IDLE,
    RC_LOAD,
    RC_RUN
  } rc_state_e;

endpackage

// ===== sv/rltb_if.sv =====
// pixel and result channel interfaces of the radial lamp tint blend
// depends on rltb_pkg
interface rltb_pix_if import rltb_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [PIX_XY_W-1:0] pixel_x;
  logic [PIX_XY_W-1:0] pixel_y;
  logic [COLOR_W-1:0]  pixel_color;

  modport source (output valid, output pixel_x, output pixel_y, output pixel_color,
                  input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, input pixel_color,
                  output ready);
endinterface

interface rltb_res_if import rltb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] out_color;
  logic               tinted;
  logic [ALPHA_W-1:0] strength;

  modport source (output valid, output out_color, output tinted, output strength,
                  input ready);
  modport sink   (input valid, input out_color, input tinted, input strength,
                  output ready);
endinterface

// ===== sv/rltb_recip.sv =====
// lamp geometry unit: r2, vmin = r2/7 and inv = ceil(7*2^16/r2)
// serial restoring divider, one quotient bit a cycle; depends on rltb_pkg
module rltb_recip import rltb_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [RADIUS_W-1:0] radius_i,
  output logic                busy_o,
  output geom_t               geom_o
);

  localparam int CNT_W = $clog2(INV_W);

  rc_state_e         state_q, state_d;
  logic [R2_W-1:0]   r2_q, r2_d;
  logic [VMIN_W-1:0] vmin_q, vmin_d;
  logic [INV_W-1:0]  inv_q, inv_d;
  logic [INV_W-1:0]  dvd_q, dvd_d;
  logic [R2_W-1:0]   rem_q, rem_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;

  logic [R2_W:0]                  trial;
  logic                           qbit;
  logic [R2_W+SEVEN_RCP_W-1:0]    vmin_prod;

  assign trial     = {rem_q, dvd_q[INV_W-1]};
  assign qbit      = (trial >= {1'b0, r2_q});
  assign vmin_prod = r2_q * SEVEN_RCP_W'(SEVEN_RECIP);

  always_comb begin
    state_d = state_q;
    r2_d    = r2_q;
    vmin_d  = vmin_q;
    inv_d   = inv_q;
    dvd_d   = dvd_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      RC_IDLE: ;
      RC_LOAD: begin
        vmin_d = vmin_prod[SEVEN_RCP_SH +: VMIN_W];
        dvd_d  = INV_W'(INV_NUM) + INV_W'(r2_q) - INV_W'(1);
        rem_d  = '0;
        cnt_d  = '0;
        // zero radius tints nothing, the reciprocal is never read
        state_d = (r2_q == '0) ? RC_IDLE : RC_RUN;
      end
      RC_RUN: begin
        rem_d = qbit ? R2_W'(trial - {1'b0, r2_q}) : trial[R2_W-1:0];
        dvd_d = {dvd_q[INV_W-2:0], qbit};
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(INV_W - 1)) begin
          inv_d   = {dvd_q[INV_W-2:0], qbit};
          state_d = RC_IDLE;
        end
      end
      default: state_d = RC_IDLE;
    endcase
    // a fresh radius write restarts the unit from any state
    if (start_i) begin
      r2_d    = R2_W'(radius_i * radius_i);
      state_d = RC_LOAD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= RC_IDLE;
      r2_q    <= R2_W'(R2_RESET);
      vmin_q  <= VMIN_W'(VMIN_RESET);
      inv_q   <= INV_W'(INV_RESET);
    end else begin
      state_q <= state_d;
      r2_q    <= r2_d;
      vmin_q  <= vmin_d;
      inv_q   <= inv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    cnt_q <= cnt_d;
  end

  assign busy_o      = start_i || (state_q != RC_IDLE);
  assign geom_o.r2   = r2_q;
  assign geom_o.vmin = vmin_q;
  assign geom_o.inv  = inv_q;

endmodule

// ===== sv/rltb_skid.sv =====
// two-entry output register with skid slot for the result channel
// ready towards the pipeline comes from a flop; depends on rltb_pkg, rltb_if
module rltb_skid import rltb_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  result_t       data_i,
  output logic          ready_o,
  rltb_res_if.source    res_o
);

  logic    out_valid_q, skid_valid_q;
  result_t out_data_q, skid_data_q;
  logic    out_free;

  assign out_free = !out_valid_q || res_o.ready;
  assign ready_o  = !skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q  <= skid_valid_q || valid_i;
      skid_valid_q <= 1'b0;
    end else if (valid_i && ready_o) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_data_q <= skid_valid_q ? skid_data_q : data_i;
    end else if (valid_i && ready_o) begin
      skid_data_q <= data_i;
    end
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.out_color = out_data_q.out_color;
  assign res_o.tinted    = out_data_q.tinted;
  assign res_o.strength  = out_data_q.strength;

endmodule

// ===== sv/radial_light_tint_blend_core.sv =====
// top level of the radial lamp tint blend: config registers, pixel pipeline
// depends on rltb_pkg, rltb_if, rltb_recip, rltb_skid
//
//  channel   dir   handshake         beat payload
//  pix_i     in    valid / ready     pixel_x, pixel_y, pixel_color
//  res_o     out   valid / ready     out_color, tinted, strength
//  cfg       in    cfg_we_i only     cfg_idx_i, cfg_data_i
//
// one pixel beat a cycle unless a radius write or a stall at res_o holds it off;
// an accepted beat passes four pipeline stages, then the output register
// a radius write holds off pixel beats while the geometry unit squares the
// radius and runs its 19-step serial divider for the reciprocal
// reset leaves no beats in flight and loads the lamp geometry of radius 16
// a stall at res_o fills the skid slot, then freezes every stage together

module radial_light_tint_blend_core import rltb_pkg::*; #(
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  rltb_pix_if.sink              pix_i,
  rltb_res_if.source            res_o
);

  localparam int SCR_W = 11;   // holds screen sizes up to 2047

  // ---------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------
  logic signed [CENTER_W-1:0] cx_q, cy_q;
  logic [TINT_W-1:0]          tint_q;
  logic                       radius_wr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q   <= '0;
      cy_q   <= '0;
      tint_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_CENTER_X: cx_q   <= cfg_data_i[CENTER_W-1:0];
        CFG_CENTER_Y: cy_q   <= cfg_data_i[CENTER_W-1:0];
        CFG_RADIUS:   ;      // held in the geometry unit
        CFG_TINT:     tint_q <= cfg_data_i[TINT_W-1:0];
      endcase
    end
  end

  assign radius_wr = cfg_we_i && (cfg_idx_e'(cfg_idx_i) == CFG_RADIUS);

  // radius derived values: r2, vmin, reciprocal
  geom_t geom;
  logic  geom_busy;

  rltb_recip u_recip (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (radius_wr),
    .radius_i (cfg_data_i[RADIUS_W-1:0]),
    .busy_o   (geom_busy),
    .geom_o   (geom)
  );

  // ---------------------------------------------------------------
  // pipeline control: all stages move together while the skid has room
  // ---------------------------------------------------------------
  logic advance;
  logic accept;

  assign pix_i.ready = advance && !geom_busy;
  assign accept      = pix_i.valid && pix_i.ready;

  logic s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= accept;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
    end
  end

  // ---------------------------------------------------------------
  // stage 1: offsets from the lamp centre, screen bounds
  // ---------------------------------------------------------------
  logic signed [CENTER_W:0] dx_d, dy_d;
  logic                     onscr_d;

  assign dx_d = $signed({3'b000, pix_i.pixel_x}) - $signed({cx_q[CENTER_W-1], cx_q});
  assign dy_d = $signed({3'b000, pix_i.pixel_y}) - $signed({cy_q[CENTER_W-1], cy_q});
  assign onscr_d = ({3'b000, pix_i.pixel_x} < SCR_W'(SCREEN_WIDTH)) &&
                   ({3'b000, pix_i.pixel_y} < SCR_W'(SCREEN_HEIGHT));

  logic signed [CENTER_W:0] s1_dx_q, s1_dy_q;
  logic                     s1_onscr_q;
  logic [COLOR_W-1:0]       s1_color_q;

  // ---------------------------------------------------------------
  // stage 2: squares of the offsets
  // ---------------------------------------------------------------
  localparam int SQ_W = 20;    // 767^2 fits

  logic signed [2*CENTER_W+1:0] dx_sq, dy_sq;

  assign dx_sq = s1_dx_q * s1_dx_q;
  assign dy_sq = s1_dy_q * s1_dy_q;

  logic [SQ_W-1:0]    s2_dx2_q, s2_dy2_q;
  logic               s2_onscr_q;
  logic [COLOR_W-1:0] s2_color_q;

  // ---------------------------------------------------------------
  // stage 3: v = r2 - dy^2 - dx^2 and the hit test
  // |dx| <= isqrt(q - vmin) is the same as dx^2 <= q - vmin, i.e. v >= vmin
  // ---------------------------------------------------------------
  localparam int V_W = SQ_W + 2;

  logic signed [V_W-1:0] v_full;
  logic                  hit_d;

  assign v_full = $signed({{(V_W-R2_W){1'b0}}, geom.r2})
                - $signed({2'b00, s2_dy2_q})
                - $signed({2'b00, s2_dx2_q});
  assign hit_d  = s2_onscr_q && (geom.r2 != '0) &&
                  (v_full >= $signed({{(V_W-VMIN_W){1'b0}}, geom.vmin}));

  logic [R2_W-1:0]    s3_v_q;   // 0..r2 whenever hit
  logic               s3_hit_q;
  logic [COLOR_W-1:0] s3_color_q;

  // ---------------------------------------------------------------
  // stage 4: strength = (v * inv) >> 16
  // ---------------------------------------------------------------
  logic [R2_W+INV_W-1:0] str_prod;

  assign str_prod = s3_v_q * geom.inv;

  logic [ALPHA_W:0]   s4_araw_q;
  logic               s4_hit_q;
  logic [COLOR_W-1:0] s4_color_q;

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_dx_q    <= dx_d;
      s1_dy_q    <= dy_d;
      s1_onscr_q <= onscr_d;
      s1_color_q <= pix_i.pixel_color;

      s2_dx2_q   <= dx_sq[SQ_W-1:0];
      s2_dy2_q   <= dy_sq[SQ_W-1:0];
      s2_onscr_q <= s1_onscr_q;
      s2_color_q <= s1_color_q;

      s3_v_q     <= v_full[R2_W-1:0];
      s3_hit_q   <= hit_d;
      s3_color_q <= s2_color_q;

      s4_araw_q  <= str_prod[16 +: ALPHA_W+1];
      s4_hit_q   <= s3_hit_q;
      s4_color_q <= s3_color_q;
    end
  end

  // ---------------------------------------------------------------
  // blend, into the output register
  // ---------------------------------------------------------------
  // c + (t - c) * a / 16, quotient truncated toward zero
  function automatic logic [CH_W-1:0] blend_ch(input logic [CH_W-1:0]    c,
                                               input logic [CH_W-1:0]    t,
                                               input logic [ALPHA_W-1:0] a);
    logic signed [CH_W:0]         diff;
    logic signed [CH_W+ALPHA_W+1:0] prod;
    logic [CH_W+ALPHA_W+1:0]      mag;
    logic [CH_W+ALPHA_W+1:0]      step;
    diff = $signed({1'b0, t}) - $signed({1'b0, c});
    prod = diff * $signed({1'b0, a});
    mag  = prod[CH_W+ALPHA_W+1] ? (~prod + 1'b1) : prod;
    step = mag >> 4;
    if (prod[CH_W+ALPHA_W+1]) begin
      return c - step[CH_W-1:0];
    end
    return c + step[CH_W-1:0];
  endfunction

  logic [ALPHA_W-1:0] alpha;
  logic               active;
  result_t            res_d;

  assign alpha  = (s4_araw_q > (ALPHA_W+1)'(MAX_ALPHA)) ? ALPHA_W'(MAX_ALPHA)
                                                         : s4_araw_q[ALPHA_W-1:0];
  assign active = s4_hit_q && (alpha != '0);

  always_comb begin
    res_d.out_color = s4_color_q;
    res_d.tinted    = 1'b0;
    res_d.strength  = '0;
    if (active) begin
      res_d.out_color = BLEND_MARK |
                        {1'b0,
                         blend_ch(s4_color_q[14:10], tint_q[14:10], alpha),
                         blend_ch(s4_color_q[9:5],   tint_q[9:5],   alpha),
                         blend_ch(s4_color_q[4:0],   tint_q[4:0],   alpha)};
      res_d.tinted    = 1'b1;
      res_d.strength  = alpha;
    end
  end

  rltb_skid u_skid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s4_valid_q && advance),
    .data_i  (res_d),
    .ready_o (advance),
    .res_o   (res_o)
  );

endmodule
